FILE: rtl/wrl_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and microcode ROM for the windowed byte rate limiter.
package wrl_pkg;

  // Program counter and loop counter widths
  localparam int PC_W  = 4;
  localparam int CNT_W = 5;
  // Width of the signed intermediate sums (base, allowance sum, doubled base)
  localparam int T_W   = 50;

  // Configuration register indexes
  typedef logic [0:0] reg_idx_t;
  localparam reg_idx_t REG_RATE    = 1'b0;
  localparam reg_idx_t REG_MAX_PKT = 1'b1;

  // Divider setup: two quotient bits per step
  localparam logic [CNT_W-1:0] DIV_SC_LAST = 5'd31;  // 64-bit dividend
  localparam logic [31:0]      MS_PER_SEC  = 32'd1000;
  // floor(x / 1000) for any 32-bit x is (x * RECIP_1000) >> RECIP_SHIFT
  localparam logic [28:0]      RECIP_1000  = 29'h1062_4DD3;
  localparam int               RECIP_SHIFT = 38;

  // Datapath operations
  typedef logic [3:0] op_t;
  localparam op_t OP_NONE       = 4'd0;
  localparam op_t OP_LOAD       = 4'd1;
  localparam op_t OP_MUL_LO     = 4'd2;
  localparam op_t OP_MUL_HI     = 4'd3;
  localparam op_t OP_DIV_INIT   = 4'd4;
  localparam op_t OP_DIV_STEP   = 4'd5;
  localparam op_t OP_RATE_INIT  = 4'd6;
  localparam op_t OP_BASE       = 4'd7;
  localparam op_t OP_TSUM       = 4'd8;
  localparam op_t OP_CLOSE      = 4'd9;
  localparam op_t OP_WIN        = 4'd10;
  localparam op_t OP_PASS       = 4'd11;
  localparam op_t OP_RATE_SPLIT = 4'd12;
  localparam op_t OP_RATE_FRAC  = 4'd13;
  localparam op_t OP_RATE_FIX   = 4'd14;

  // Sequencer branch conditions
  typedef logic [2:0] cond_t;
  localparam cond_t C_NEXT    = 3'd0;  // fall through
  localparam cond_t C_JUMP    = 3'd1;  // always branch
  localparam cond_t C_WAIT_IN = 3'd2;  // hold until an input transfer
  localparam cond_t C_RATE0   = 3'd3;  // branch when limiting is off
  localparam cond_t C_INWIN   = 3'd4;  // branch when still inside the window
  localparam cond_t C_LOOP    = 3'd5;  // branch back until the divider is done
  localparam cond_t C_EMIT    = 3'd6;  // hold until the output slot is free, then branch

  typedef logic [PC_W-1:0] pc_t;
  localparam pc_t PC_IDLE   = 4'd0;
  localparam pc_t PC_DIV_SC = 4'd5;
  localparam pc_t PC_WIN    = 4'd13;
  localparam pc_t PC_PASS   = 4'd14;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } ucode_t;

  typedef struct packed {
    logic in_fire;
    logic rate_zero;
    logic in_win;
    logic div_last;
    logic out_free;
  } stat_t;

  // Control store
  function automatic ucode_t ucode_rom(input pc_t pc);
    ucode_t w;
    unique case (pc)
      4'd0:    w = '{OP_LOAD,       C_WAIT_IN, PC_IDLE};
      4'd1:    w = '{OP_NONE,       C_RATE0,   PC_PASS};
      4'd2:    w = '{OP_MUL_LO,     C_INWIN,   PC_WIN};
      4'd3:    w = '{OP_MUL_HI,     C_NEXT,    PC_IDLE};
      4'd4:    w = '{OP_DIV_INIT,   C_NEXT,    PC_IDLE};
      4'd5:    w = '{OP_DIV_STEP,   C_LOOP,    PC_DIV_SC};
      4'd6:    w = '{OP_RATE_INIT,  C_NEXT,    PC_IDLE};
      4'd7:    w = '{OP_RATE_SPLIT, C_NEXT,    PC_IDLE};
      4'd8:    w = '{OP_RATE_FRAC,  C_NEXT,    PC_IDLE};
      4'd9:    w = '{OP_RATE_FIX,   C_NEXT,    PC_IDLE};
      4'd10:   w = '{OP_BASE,       C_NEXT,    PC_IDLE};
      4'd11:   w = '{OP_TSUM,       C_NEXT,    PC_IDLE};
      4'd12:   w = '{OP_CLOSE,      C_EMIT,    PC_IDLE};
      4'd13:   w = '{OP_WIN,        C_EMIT,    PC_IDLE};
      4'd14:   w = '{OP_PASS,       C_EMIT,    PC_IDLE};
      default: w = '{OP_NONE,       C_JUMP,    PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/wrl_seq.sv
`timescale 1ns / 1ps
// Microcode sequencer: step counter, control store lookup and branch logic.
module wrl_seq (
  input  logic            clk,
  input  logic            rst,
  input  wrl_pkg::stat_t  stat,
  output wrl_pkg::ucode_t ctrl
);
  import wrl_pkg::*;

  pc_t pc;
  pc_t pc_next;
  pc_t pc_inc;

  assign ctrl   = ucode_rom(pc);
  assign pc_inc = pc + 4'd1;

  // Next step selection
  always_comb begin
    unique case (ctrl.cond)
      C_NEXT:    pc_next = pc_inc;
      C_JUMP:    pc_next = ctrl.target;
      C_WAIT_IN: pc_next = stat.in_fire ? pc_inc : pc;
      C_RATE0:   pc_next = stat.rate_zero ? ctrl.target : pc_inc;
      C_INWIN:   pc_next = stat.in_win ? ctrl.target : pc_inc;
      C_LOOP:    pc_next = stat.div_last ? pc_inc : ctrl.target;
      C_EMIT:    pc_next = stat.out_free ? ctrl.target : pc;
      default:   pc_next = PC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

FILE: rtl/windowed_byte_rate_limiter.sv
`timescale 1ns / 1ps
// Windowed byte rate limiter: top level with datapath and result register.
//
// Each input transfer carries a packet's timestamp and byte count; each yields
// exactly one result transfer saying whether the packet may go out and whether
// it opened a new counting window. Items are handled one at a time by a
// microcoded sequencer; in_tready is high only while the sequencer waits for
// work.
// Steps from input transfer to result valid:
//   limiting off (rate 0): the rate check, then the pass step
//   inside a window:       the rate check, the window check, then the window step
//   window close:          four setup steps, 32 divider steps (two
//                          quotient bits per cycle) for the rescaled byte
//                          count, four steps that scale the rate to one window
//                          with a reciprocal multiply, three for the allowance.
// A new item can be taken as soon as the previous result is registered.
// The result register holds a finished result while the receiver stalls; the
// sequencer parks on the emit step until that slot frees up.
// Reset (synchronous, rst) clears the window, byte count and allowance, sets
// the rate to 0 and max packet size to 1500; no clearing pass is needed.
// Configuration writes are taken on any cycle with cfg_wr_en high.
module windowed_byte_rate_limiter #(
  parameter int WINDOW_MS = 500
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [47:0]       in_tdata,    // [31:0] now_ms, [47:32] packet_bytes
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,   // [0] admit, [1] window_restarted, [7:2] zero
  input  logic              cfg_wr_en,
  input  wrl_pkg::reg_idx_t cfg_index,
  input  logic [31:0]       cfg_wdata
);
  import wrl_pkg::*;

  localparam int               WIN_W    = $clog2(WINDOW_MS + 1);
  localparam logic [WIN_W-1:0] WIN_C    = WIN_W'(WINDOW_MS);
  localparam logic [31:0]      WIN_MS32 = 32'(WINDOW_MS);
  localparam logic signed [T_W-1:0] ALLOW_MAX_T = {3'b000, {47{1'b1}}};
  localparam logic signed [T_W-1:0] ALLOW_MIN_T = {3'b111, {47{1'b0}}};

  ucode_t ctrl;
  stat_t  stat;

  // Architectural state
  logic [31:0]        rate;
  logic [15:0]        mps;
  logic [31:0]        wstart;
  logic [47:0]        bsent;
  logic signed [47:0] allow;

  // Scratch registers
  logic [31:0]           now_r;
  logic [15:0]           pkt_r;
  logic [63:0]           acc;
  logic [31:0]           rem;
  logic [31:0]           dvsr;
  logic [CNT_W-1:0]      cnt;
  logic [47:0]           scaled;
  logic signed [T_W-1:0] base;
  logic signed [T_W-1:0] tval;
  logic                  admit_r;
  logic                  restart_r;

  logic [31:0]                   diff;
  logic [23+WIN_W:0]             p_lo;
  logic [23+WIN_W:0]             p_hi;
  logic [31:0]                   recip_in;
  logic [60:0]                   recip_prod;
  logic [63-RECIP_SHIFT:0]       q_ms;
  logic [63-RECIP_SHIFT+WIN_W:0] whole_ms;
  logic [9+WIN_W:0]              frac_ms;
  logic [32:0]                   r1;
  logic [32:0]                   r2;
  logic                          q1;
  logic                          q2;
  logic [31:0]                   r1m;
  logic [31:0]                   rem_step;
  logic [63:0]                   acc_step;
  logic signed [T_W-1:0]         cap;
  logic signed [T_W-1:0]         tmin;
  logic signed [47:0]            allow_new;
  logic [48:0]                   sum;
  logic [47:0]                   lim;
  logic                          fits;
  logic                          emit;

  wrl_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  // Handshake and status toward the sequencer
  assign in_tready      = (ctrl.cond == C_WAIT_IN);
  assign diff           = now_r - wstart;
  assign stat.in_fire   = in_tvalid && in_tready;
  assign stat.rate_zero = (rate == 32'd0);
  assign stat.in_win    = (diff < WIN_MS32);
  assign stat.div_last  = (cnt == '0);
  assign stat.out_free  = !out_tvalid || out_tready;
  assign emit = stat.out_free &&
                (ctrl.op == OP_CLOSE || ctrl.op == OP_WIN || ctrl.op == OP_PASS);

  // Partial products, each 24 bits by the WIN_W-bit window length
  assign p_lo = bsent[23:0] * WIN_C;
  assign p_hi = bsent[47:24] * WIN_C;

  // Per-window rate: rate = 1000 * q + r, so rate * W / 1000 = q * W + r * W / 1000.
  // One reciprocal multiplier serves both divisions by 1000.
  assign recip_in   = (ctrl.op == OP_RATE_FIX) ? rem : rate;
  assign recip_prod = recip_in * RECIP_1000;
  assign q_ms       = acc[63:RECIP_SHIFT];
  assign whole_ms   = q_ms * WIN_C;
  assign frac_ms    = rem[9:0] * WIN_C;

  // Restoring divider, two quotient bits per step
  always_comb begin
    r1       = {rem, acc[63]};
    q1       = (r1 >= {1'b0, dvsr});
    r1m      = q1 ? 32'(r1 - {1'b0, dvsr}) : r1[31:0];
    r2       = {r1m, acc[62]};
    q2       = (r2 >= {1'b0, dvsr});
    rem_step = q2 ? 32'(r2 - {1'b0, dvsr}) : r2[31:0];
    acc_step = {acc[61:0], q1, q2};
  end

  // New allowance: min against twice the base, then saturate to 48 bits
  always_comb begin
    cap  = base <<< 1;
    tmin = (tval < cap) ? tval : cap;
    if (tmin > ALLOW_MAX_T) begin
      allow_new = ALLOW_MAX_T[47:0];
    end else if (tmin < ALLOW_MIN_T) begin
      allow_new = ALLOW_MIN_T[47:0];
    end else begin
      allow_new = tmin[47:0];
    end
  end

  // Inside-window check; a negative allowance counts as zero
  always_comb begin
    sum  = {1'b0, bsent} + {33'd0, pkt_r};
    lim  = allow[47] ? 48'd0 : allow;
    fits = (sum <= {1'b0, lim});
  end

  // Configuration and window state
  always_ff @(posedge clk) begin
    if (rst) begin
      rate   <= 32'd0;
      mps    <= 16'd1500;
      wstart <= 32'd0;
      bsent  <= 48'd0;
      allow  <= 48'sd0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_RATE:    rate <= cfg_wdata;
          REG_MAX_PKT: mps  <= cfg_wdata[15:0];
        endcase
      end
      if (emit && ctrl.op == OP_CLOSE) begin
        allow  <= allow_new;
        bsent  <= {32'd0, pkt_r};
        wstart <= now_r;
      end else if (emit && ctrl.op == OP_WIN && fits) begin
        bsent  <= sum[47:0];
      end
    end
  end

  // Datapath steps driven by the control word
  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      OP_LOAD: begin
        if (stat.in_fire) begin
          now_r <= in_tdata[31:0];
          pkt_r <= in_tdata[47:32];
        end
      end
      OP_MUL_LO: acc <= 64'(p_lo);
      OP_MUL_HI: acc <= acc + (64'(p_hi) << 24);
      OP_DIV_INIT: begin
        rem  <= 32'd0;
        dvsr <= diff;
        cnt  <= DIV_SC_LAST;
      end
      OP_DIV_STEP: begin
        acc <= acc_step;
        rem <= rem_step;
        cnt <= cnt - 5'd1;
      end
      OP_RATE_INIT: begin
        scaled <= acc[47:0];
        acc    <= 64'(recip_prod);
      end
      // whole bytes per millisecond times the window, and the leftover bytes per second
      OP_RATE_SPLIT: begin
        rem  <= rate - q_ms * MS_PER_SEC;
        base <= T_W'(whole_ms);
      end
      OP_RATE_FRAC: rem <= 32'(frac_ms);
      OP_RATE_FIX:  acc <= 64'(recip_prod);
      OP_BASE: base <= $signed(base + T_W'(q_ms) + T_W'(mps) - T_W'(1));
      OP_TSUM: tval <= base + $signed({{(T_W-48){allow[47]}}, allow})
                            - $signed({{(T_W-48){1'b0}}, scaled});
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_tvalid <= 1'b0;
    end else if (emit) begin
      out_tvalid <= 1'b1;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      admit_r   <= (ctrl.op != OP_WIN) || fits;
      restart_r <= (ctrl.op == OP_CLOSE);
    end
  end

  assign out_tdata = {6'd0, restart_r, admit_r};

  // A restarted window always admits its packet
  a_restart_admits: assert property (@(posedge clk) disable iff (rst)
    out_tvalid |-> (!out_tdata[1] || out_tdata[0]))
    else $error("window restart without admit");

  // Byte count never leaves the positive allowance range
  a_bsent_range: assert property (@(posedge clk) disable iff (rst)
    !bsent[47])
    else $error("bytes sent overflowed allowance range");

  // Sequencer leaves the wait step right after taking an item
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted twice in a row");

  // Partial remainder stays below the divisor during division
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == OP_DIV_STEP) |-> (rem < dvsr))
    else $error("divider remainder out of range");

endmodule
